### hdl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants of the lidar point decimation filter
// Coordinate widths, configuration register indexes, result kinds and the
// fixed-point constants of the time conversion.
// ----------------------------------------------------------------------------
package lpd_pkg;

    // Coordinate and squared-range widths
    localparam int COORD_BITS = 24;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int RSQ_W      = SQ_W + 2;
    localparam int RANGE_W    = 48;
    localparam int CMP_W      = (RSQ_W > RANGE_W) ? RSQ_W : RANGE_W;

    // Configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECIM,
        CFG_MIN_RSQ,
        CFG_MAX_RSQ,
        CFG_MAX_TIME,
        CFG_TIME_MODE,
        CFG_HDR_TIME,
        CFG_TIME_PRESENT
    } cfg_index_t;

    // Time modes; any other code is taken as relative nanoseconds
    localparam logic [1:0] TMODE_ABS_S = 2'd0;
    localparam logic [1:0] TMODE_REL_S = 2'd1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_POINT,
        KIND_TIME_ERR,
        KIND_DONE,
        KIND_EMPTY
    } kind_t;

    // Time conversion constants
    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [9:0]  NS_PER_US  = 10'd1000;
    localparam logic [31:0] NEG_TOL_US = 32'd100;

    // Nanosecond to microsecond: q = (n * NS_RECIP) >> NS_SHIFT, exact for
    // n below 2^NS_IN_W
    localparam int          NS_IN_W  = 42;
    localparam int          NS_HALF  = 21;
    localparam int          NS_SHIFT = 52;
    localparam int          NS_PROD_W = 85;
    localparam logic [42:0] NS_RECIP = 43'd4503599627371;

    // Reset values of the registers
    localparam logic [7:0]  DECIM_RST    = 8'd1;
    localparam logic [47:0] MAX_RSQ_RST  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX_TIME_RST = 32'd100000;

    // One result item
    typedef struct packed {
        kind_t                         kind;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  z;
        logic [31:0]                   intensity;
        logic [31:0]                   offset;
        logic [31:0]                   max_offset;
        logic                          run_last;
    } result_t;

endpackage

### hdl/lpd_if.sv
// ----------------------------------------------------------------------------
// lpd_if: stream channels of the lidar point decimation filter
// Point channel into the block and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpd_point_if;
    import lpd_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_mm;
    logic signed [COORD_BITS-1:0] y_mm;
    logic signed [COORD_BITS-1:0] z_mm;
    logic [31:0]                  intensity_bits;
    logic                         coords_finite;
    logic [63:0]                  raw_time;
    logic                         time_finite;
    logic                         last_point;

    modport source (
        output valid, x_mm, y_mm, z_mm, intensity_bits, coords_finite,
               raw_time, time_finite, last_point,
        input  ready
    );

    modport sink (
        input  valid, x_mm, y_mm, z_mm, intensity_bits, coords_finite,
               raw_time, time_finite, last_point,
        output ready
    );
endinterface

interface lpd_result_if;
    import lpd_pkg::*;

    logic                         valid;
    logic                         ready;
    kind_t                        kind;
    logic signed [COORD_BITS-1:0] out_x_mm;
    logic signed [COORD_BITS-1:0] out_y_mm;
    logic signed [COORD_BITS-1:0] out_z_mm;
    logic [31:0]                  out_intensity_bits;
    logic [31:0]                  offset_us;
    logic [31:0]                  max_offset_us;
    logic                         run_last;

    modport source (
        output valid, kind, out_x_mm, out_y_mm, out_z_mm, out_intensity_bits,
               offset_us, max_offset_us, run_last,
        input  ready
    );

    modport sink (
        input  valid, kind, out_x_mm, out_y_mm, out_z_mm, out_intensity_bits,
               offset_us, max_offset_us, run_last,
        output ready
    );
endinterface

### hdl/lidar_point_decimate_range_time_filter.sv
// ----------------------------------------------------------------------------
// lidar_point_decimate_range_time_filter: lidar point decimation and filter
// Converts point timestamps to microsecond offsets, aborts a cloud on a time
// error, keeps every Nth point if it is finite and inside the squared-range
// window and closes each cloud with a summary or a no-points result.
// ----------------------------------------------------------------------------
// Usage:
//   points  : one lidar point per transaction; last_point closes the cloud.
//   results : kept points, time errors and end-of-cloud summaries, one per
//             transaction; run_last marks the final result of a point.
//   cfg_*   : register writes; the user must make them only while the
//             block is idle, which the block itself does not enforce.
// Path: a point passes stage registers s1 to s4 into the result queue; a
//   second result (end of cloud) is written with the first and follows it.
// Throughput: one point per cycle through a four-stage pipeline while the
//   queue has room; a point that closes a cloud after a kept point gives
//   two results. The limit is the four-entry result queue.
// Reset: registers return to their reset values, the pipeline and queue
//   empty, and the cloud state (phase, max offset, abort) clears.
// Stall: the queue absorbs results while the receiver stalls; once fewer
//   than two entries are free the pipeline holds and points.ready drops.
// ----------------------------------------------------------------------------
module lidar_point_decimate_range_time_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpd_pkg::CFG_W-1:0]      cfg_wdata,
    lpd_point_if.sink                      points,
    lpd_result_if.source                   results
);
    import lpd_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Pipeline stage contents
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [31:0]                  intensity;
        logic                         cfin;
        logic [63:0]                  raw;
        logic                         tfin;
        logic                         last;
    } s1_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [31:0]                  intensity;
        logic                         cfin;
        logic                         tfin;
        logic                         last;
        logic [SQ_W-1:0]              sq_x;
        logic [SQ_W-1:0]              sq_y;
        logic [SQ_W-1:0]              sq_z;
        logic                         neg;
        logic [63:0]                  tq;
    } s2_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [31:0]                  intensity;
        logic                         usable;
        logic                         tfin;
        logic                         last;
        logic                         neg;
        logic [51:0]                  hi_p;
        logic [51:0]                  lo_p;
        logic [42:0]                  pp_hh;
        logic [41:0]                  pp_hl;
        logic [42:0]                  pp_lh;
        logic [41:0]                  pp_ll;
        logic                         ns_big;
        logic [NS_IN_W-1:0]           ns_val;
        logic [NS_IN_W-1:0]           lim_ns;
    } s3_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [31:0]                  intensity;
        logic                         usable;
        logic                         last;
        logic                         terr;
        logic [31:0]                  offset;
    } s4_t;

    // Configuration registers
    logic [7:0]         decim_reg;
    logic [RANGE_W-1:0] min_rsq_reg;
    logic [RANGE_W-1:0] max_rsq_reg;
    logic [31:0]        max_time_reg;
    logic [1:0]         time_mode_reg;
    logic [63:0]        hdr_time_reg;
    logic               time_present_reg;

    // Pipeline
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    logic flow;

    // Cloud state
    logic [7:0]  phase_count_reg, phase_count_next;
    logic [31:0] max_offset_reg, max_offset_next;
    logic        aborted_reg, aborted_next;
    logic        any_kept_reg, any_kept_next;

    // Result queue
    result_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_p1;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        push_cnt;
    logic              pop;
    result_t           ent0, ent1, head;

    // Stage two helpers
    logic signed [SQ_W-1:0] sx2, sy2, sz2;
    logic                   raw_lt_hdr;

    // Stage three helpers
    logic [RSQ_W-1:0]   rsq;
    logic [NS_IN_W-1:0] ns_n;

    // Stage four helpers
    logic [52:0]          mag;
    logic                 frac;
    logic                 err_sec;
    logic                 err_ns;
    logic                 is_ns;
    logic [NS_PROD_W-1:0] ns_sum;
    logic [31:0]          ns_q;

    // Final stage helpers
    logic [7:0]  factor;
    logic [8:0]  phase_inc;
    logic        kept;
    logic [31:0] max_new;
    result_t     pt_ent, end_ent;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_reg        <= DECIM_RST;
            min_rsq_reg      <= '0;
            max_rsq_reg      <= MAX_RSQ_RST;
            max_time_reg     <= MAX_TIME_RST;
            time_mode_reg    <= TMODE_REL_S;
            hdr_time_reg     <= '0;
            time_present_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_DECIM:        decim_reg        <= cfg_wdata[7:0];
                CFG_MIN_RSQ:      min_rsq_reg      <= cfg_wdata[RANGE_W-1:0];
                CFG_MAX_RSQ:      max_rsq_reg      <= cfg_wdata[RANGE_W-1:0];
                CFG_MAX_TIME:     max_time_reg     <= cfg_wdata[31:0];
                CFG_TIME_MODE:    time_mode_reg    <= cfg_wdata[1:0];
                CFG_HDR_TIME:     hdr_time_reg     <= cfg_wdata;
                CFG_TIME_PRESENT: time_present_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Advance the whole pipeline while the queue has room for two results
    assign flow         = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign points.ready = flow;

    // ------------------------------------------------------------------
    // Stage one: capture the input transaction
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_next.x         = points.x_mm;
        s1_next.y         = points.y_mm;
        s1_next.z         = points.z_mm;
        s1_next.intensity = points.intensity_bits;
        s1_next.cfin      = points.coords_finite;
        s1_next.raw       = points.raw_time;
        s1_next.tfin      = points.time_finite;
        s1_next.last      = points.last_point;
    end

    // ------------------------------------------------------------------
    // Stage two: squares and signed time difference
    // ------------------------------------------------------------------
    assign sx2        = $signed(s1_reg.x) * $signed(s1_reg.x);
    assign sy2        = $signed(s1_reg.y) * $signed(s1_reg.y);
    assign sz2        = $signed(s1_reg.z) * $signed(s1_reg.z);
    assign raw_lt_hdr = s1_reg.raw < hdr_time_reg;

    always_comb
    begin
        s2_next.x         = s1_reg.x;
        s2_next.y         = s1_reg.y;
        s2_next.z         = s1_reg.z;
        s2_next.intensity = s1_reg.intensity;
        s2_next.cfin      = s1_reg.cfin;
        s2_next.tfin      = s1_reg.tfin;
        s2_next.last      = s1_reg.last;
        s2_next.sq_x      = $unsigned(sx2);
        s2_next.sq_y      = $unsigned(sy2);
        s2_next.sq_z      = $unsigned(sz2);
        s2_next.neg       = (time_mode_reg == TMODE_ABS_S) && raw_lt_hdr;
        if (time_mode_reg == TMODE_ABS_S)
        begin
            s2_next.tq = raw_lt_hdr ? (hdr_time_reg - s1_reg.raw)
                                    : (s1_reg.raw - hdr_time_reg);
        end
        else
        begin
            s2_next.tq = s1_reg.raw;
        end
    end

    // ------------------------------------------------------------------
    // Stage three: range window, scaling products, nanosecond partials
    // ------------------------------------------------------------------
    assign rsq  = RSQ_W'(s2_reg.sq_x) + RSQ_W'(s2_reg.sq_y) + RSQ_W'(s2_reg.sq_z);
    assign ns_n = s2_reg.tq[NS_IN_W-1:0];

    always_comb
    begin
        s3_next.x         = s2_reg.x;
        s3_next.y         = s2_reg.y;
        s3_next.z         = s2_reg.z;
        s3_next.intensity = s2_reg.intensity;
        s3_next.usable    = s2_reg.cfin
                            && (CMP_W'(rsq) >= CMP_W'(min_rsq_reg))
                            && (CMP_W'(rsq) <= CMP_W'(max_rsq_reg));
        s3_next.tfin      = s2_reg.tfin;
        s3_next.last      = s2_reg.last;
        s3_next.neg       = s2_reg.neg;
        s3_next.hi_p      = 52'(s2_reg.tq[63:32]) * 52'(US_PER_S);
        s3_next.lo_p      = 52'(s2_reg.tq[31:0]) * 52'(US_PER_S);
        s3_next.pp_hh     = 43'(ns_n[NS_IN_W-1:NS_HALF]) * 43'(NS_RECIP[42:NS_HALF]);
        s3_next.pp_hl     = 42'(ns_n[NS_IN_W-1:NS_HALF]) * 42'(NS_RECIP[NS_HALF-1:0]);
        s3_next.pp_lh     = 43'(ns_n[NS_HALF-1:0]) * 43'(NS_RECIP[42:NS_HALF]);
        s3_next.pp_ll     = 42'(ns_n[NS_HALF-1:0]) * 42'(NS_RECIP[NS_HALF-1:0]);
        s3_next.ns_big    = |s2_reg.tq[63:NS_IN_W];
        s3_next.ns_val    = ns_n;
        s3_next.lim_ns    = NS_IN_W'(max_time_reg) * NS_IN_W'(NS_PER_US);
    end

    // ------------------------------------------------------------------
    // Stage four: assemble the offset and test the time limits
    // ------------------------------------------------------------------
    assign mag    = 53'(s3_reg.hi_p) + 53'(s3_reg.lo_p[51:32]);
    assign frac   = |s3_reg.lo_p[31:0];
    assign ns_sum = (NS_PROD_W'(s3_reg.pp_hh) << (2 * NS_HALF))
                    + ((NS_PROD_W'(s3_reg.pp_hl) + NS_PROD_W'(s3_reg.pp_lh)) << NS_HALF)
                    + NS_PROD_W'(s3_reg.pp_ll);
    assign ns_q   = ns_sum[NS_SHIFT +: 32];
    assign is_ns  = (time_mode_reg != TMODE_ABS_S) && (time_mode_reg != TMODE_REL_S);

    // An integer nanosecond count errs exactly when it exceeds max_time * 1000
    assign err_ns = s3_reg.ns_big || (s3_reg.ns_val > s3_reg.lim_ns);

    always_comb
    begin
        if (s3_reg.neg)
        begin
            err_sec = (mag > 53'(NEG_TOL_US)) || ((mag == 53'(NEG_TOL_US)) && frac);
        end
        else
        begin
            err_sec = (mag > 53'(max_time_reg)) || ((mag == 53'(max_time_reg)) && frac);
        end
    end

    always_comb
    begin
        s4_next.x         = s3_reg.x;
        s4_next.y         = s3_reg.y;
        s4_next.z         = s3_reg.z;
        s4_next.intensity = s3_reg.intensity;
        s4_next.usable    = s3_reg.usable;
        s4_next.last      = s3_reg.last;
        s4_next.terr      = time_present_reg
                            && (!s3_reg.tfin || (is_ns ? err_ns : err_sec));
        if (!time_present_reg || (!is_ns && s3_reg.neg))
        begin
            s4_next.offset = '0;
        end
        else if (is_ns)
        begin
            s4_next.offset = ns_q;
        end
        else
        begin
            s4_next.offset = mag[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (flow)
        begin
            s1_valid_reg <= points.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // Final stage: cloud state, decimation and result generation
    // ------------------------------------------------------------------
    assign factor    = (decim_reg == '0) ? 8'd1 : decim_reg;
    assign phase_inc = {1'b0, phase_count_reg} + 9'd1;
    assign kept      = (phase_count_reg == '0) && s4_reg.usable;
    assign max_new   = (s4_reg.offset > max_offset_reg) ? s4_reg.offset : max_offset_reg;

    always_comb
    begin
        pt_ent            = '0;
        pt_ent.kind       = KIND_POINT;
        pt_ent.x          = s4_reg.x;
        pt_ent.y          = s4_reg.y;
        pt_ent.z          = s4_reg.z;
        pt_ent.intensity  = s4_reg.intensity;
        pt_ent.offset     = s4_reg.offset;
        pt_ent.run_last   = !s4_reg.last;

        end_ent           = '0;
        end_ent.kind      = (any_kept_reg || kept) ? KIND_DONE : KIND_EMPTY;
        end_ent.max_offset = (any_kept_reg || kept) ? max_new : '0;
        end_ent.run_last  = 1'b1;
    end

    always_comb
    begin
        phase_count_next = phase_count_reg;
        max_offset_next  = max_offset_reg;
        aborted_next     = aborted_reg;
        any_kept_next    = any_kept_reg;
        push_cnt         = 2'd0;
        ent0             = '0;
        ent1             = '0;

        if (flow && s4_valid_reg)
        begin
            if (aborted_reg)
            begin
                // Drop the rest of an aborted cloud; its end clears the state
                if (s4_reg.last)
                begin
                    phase_count_next = '0;
                    max_offset_next  = '0;
                    aborted_next     = 1'b0;
                    any_kept_next    = 1'b0;
                end
            end
            else if (s4_reg.terr)
            begin
                ent0          = '0;
                ent0.kind     = KIND_TIME_ERR;
                ent0.run_last = 1'b1;
                push_cnt      = 2'd1;
                if (s4_reg.last)
                begin
                    phase_count_next = '0;
                    max_offset_next  = '0;
                    aborted_next     = 1'b0;
                    any_kept_next    = 1'b0;
                end
                else
                begin
                    aborted_next = 1'b1;
                end
            end
            else
            begin
                max_offset_next  = max_new;
                phase_count_next = (phase_inc >= {1'b0, factor}) ? '0 : phase_inc[7:0];
                any_kept_next    = any_kept_reg || kept;

                if (kept && s4_reg.last)
                begin
                    ent0     = pt_ent;
                    ent1     = end_ent;
                    push_cnt = 2'd2;
                end
                else if (kept)
                begin
                    ent0     = pt_ent;
                    push_cnt = 2'd1;
                end
                else if (s4_reg.last)
                begin
                    ent0     = end_ent;
                    push_cnt = 2'd1;
                end

                // Close the cloud
                if (s4_reg.last)
                begin
                    phase_count_next = '0;
                    max_offset_next  = '0;
                    aborted_next     = 1'b0;
                    any_kept_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= '0;
            max_offset_reg  <= '0;
            aborted_reg     <= 1'b0;
            any_kept_reg    <= 1'b0;
        end
        else
        begin
            phase_count_reg <= phase_count_next;
            max_offset_reg  <= max_offset_next;
            aborted_reg     <= aborted_next;
            any_kept_reg    <= any_kept_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign pop         = results.valid && results.ready;
    assign wr_ptr_p1   = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= ent0;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_mem[wr_ptr_p1] <= ent1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Drive the result channel from the queue head
    assign head                       = fifo_mem[rd_ptr_reg];
    assign results.valid              = (count_reg != '0);
    assign results.kind               = head.kind;
    assign results.out_x_mm           = head.x;
    assign results.out_y_mm           = head.y;
    assign results.out_z_mm           = head.z;
    assign results.out_intensity_bits = head.intensity;
    assign results.offset_us          = head.offset;
    assign results.max_offset_us      = head.max_offset;
    assign results.run_last           = head.run_last;

`ifndef NO_ASSERTIONS
    // Queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // End of cloud leaves the cloud state cleared
    a_cloud_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (flow && s4_valid_reg && s4_reg.last) |=>
            (phase_count_reg == '0 && max_offset_reg == '0
             && !aborted_reg && !any_kept_reg))
        else $error("cloud state not cleared at end of cloud");

    // A time error result always carries run_last: it is the only result of its point
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind == KIND_TIME_ERR) |-> results.run_last)
        else $error("time error result without run_last");

    // While stalled the final stage does not push results
    a_stall_push: assert property (@(posedge clk) disable iff (!rst_n)
        !flow |-> (push_cnt == 2'd0))
        else $error("result pushed while pipeline stalled");
`endif

endmodule

### tb/sv/lpd_cloud_checker.sv
// ----------------------------------------------------------------------------
// lpd_cloud_checker: result checker for the lidar point decimation filter
// Watches the point and result channels and the register port, works out
// the results of every accepted point from its own copy of the cloud state
// and compares each result transaction, field by field, in order.
// ----------------------------------------------------------------------------
module lpd_cloud_checker
    import lpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    lpd_point_if                 pts,
    lpd_result_if                res,
    output int                   fail_count,
    output int                   pending
);

    localparam logic [63:0] USEC_PER_SEC  = 64'd1000000;
    localparam logic [63:0] NSEC_PER_USEC = 64'd1000;
    localparam logic [63:0] NEG_LIMIT_US  = 64'd100;

    // Register copies
    logic [7:0]  decim_r;
    logic [47:0] min_rsq_r;
    logic [47:0] max_rsq_r;
    logic [31:0] max_us_r;
    logic [1:0]  mode_r;
    logic [63:0] hdr_r;
    logic        tpres_r;

    // Cloud state
    logic [7:0]  phase_ct;
    logic [31:0] peak_us;
    logic        cloud_aborted;
    logic        cloud_kept;

    // Results owed by the block, oldest first
    result_t     cloud_results[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Q32.32 seconds to whole microseconds; flag any fractional remainder
    function automatic logic [63:0] q32_to_us(input logic [63:0] q, output logic frac);
        logic [63:0] p;
        p    = {32'd0, q[31:0]} * USEC_PER_SEC;
        frac = (p[31:0] != 32'd0);
        return (q >> 32) * USEC_PER_SEC + (p >> 32);
    endfunction

    function automatic logic [63:0] square_mm(input logic signed [COORD_BITS-1:0] v);
        longint a;
        a = v;
        if (a < 0)
            a = -a;
        return a * a;
    endfunction

    task automatic clear_cloud();
        phase_ct      = '0;
        peak_us       = '0;
        cloud_aborted = 1'b0;
        cloud_kept    = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Work out the results of one accepted point and queue them
    task automatic filter_point();
        logic [63:0] mag;
        logic [63:0] span;
        logic [63:0] off;
        logic [63:0] rsq;
        logic        frac;
        logic        neg;
        logic        bad;
        logic [7:0]  factor;
        logic        keep;
        int          n0;
        result_t     r;

        mag  = '0;
        off  = '0;
        frac = 1'b0;
        neg  = 1'b0;

        // Drop everything after an abort; the cloud end only clears state
        if (cloud_aborted)
        begin
            if (pts.last_point)
                clear_cloud();
            return;
        end

        if (tpres_r)
        begin
            if (mode_r == TMODE_ABS_S)
            begin
                neg  = pts.raw_time < hdr_r;
                span = neg ? hdr_r - pts.raw_time : pts.raw_time - hdr_r;
                mag  = q32_to_us(span, frac);
            end
            else if (mode_r == TMODE_REL_S)
            begin
                mag = q32_to_us(pts.raw_time, frac);
            end
            else
            begin
                mag  = pts.raw_time / NSEC_PER_USEC;
                frac = (pts.raw_time % NSEC_PER_USEC) != 64'd0;
            end

            if (neg)
                bad = mag > NEG_LIMIT_US || (mag == NEG_LIMIT_US && frac);
            else
                bad = mag > {32'd0, max_us_r} || (mag == {32'd0, max_us_r} && frac);

            // Abort the cloud on a time error
            if (!pts.time_finite || bad)
            begin
                r          = '0;
                r.kind     = KIND_TIME_ERR;
                r.run_last = 1'b1;
                cloud_results.push_back(r);
                if (pts.last_point)
                    clear_cloud();
                else
                    cloud_aborted = 1'b1;
                return;
            end

            off = neg ? 64'd0 : mag;
            if (off > {32'd0, peak_us})
                peak_us = off[31:0];
        end

        // Advance the decimation phase; wrap once it reaches the factor
        factor = (decim_r == 8'd0) ? 8'd1 : decim_r;
        keep   = (phase_ct == 8'd0);
        if (int'(phase_ct) + 1 >= int'(factor))
            phase_ct = '0;
        else
            phase_ct = phase_ct + 8'd1;

        rsq = square_mm(pts.x_mm) + square_mm(pts.y_mm) + square_mm(pts.z_mm);
        n0  = cloud_results.size();

        if (keep && pts.coords_finite && rsq >= {16'd0, min_rsq_r} && rsq <= {16'd0, max_rsq_r})
        begin
            r           = '0;
            r.kind      = KIND_POINT;
            r.x         = pts.x_mm;
            r.y         = pts.y_mm;
            r.z         = pts.z_mm;
            r.intensity = pts.intensity_bits;
            r.offset    = off[31:0];
            cloud_results.push_back(r);
            cloud_kept = 1'b1;
        end

        // Close the cloud with a summary or a no-points result
        if (pts.last_point)
        begin
            r = '0;
            if (cloud_kept)
            begin
                r.kind       = KIND_DONE;
                r.max_offset = peak_us;
            end
            else
            begin
                r.kind = KIND_EMPTY;
            end
            cloud_results.push_back(r);
            clear_cloud();
        end

        if (cloud_results.size() > n0)
            cloud_results[$].run_last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t due;

        if (!rst_n)
        begin
            decim_r   = 8'd1;
            min_rsq_r = '0;
            max_rsq_r = '1;
            max_us_r  = 32'd100000;
            mode_r    = TMODE_REL_S;
            hdr_r     = '0;
            tpres_r   = 1'b1;
            clear_cloud();
            cloud_results.delete();
            pending <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_DECIM:        decim_r   = cfg_wdata[7:0];
                    CFG_MIN_RSQ:      min_rsq_r = cfg_wdata[47:0];
                    CFG_MAX_RSQ:      max_rsq_r = cfg_wdata[47:0];
                    CFG_MAX_TIME:     max_us_r  = cfg_wdata[31:0];
                    CFG_TIME_MODE:    mode_r    = cfg_wdata[1:0];
                    CFG_HDR_TIME:     hdr_r     = cfg_wdata;
                    CFG_TIME_PRESENT: tpres_r   = cfg_wdata[0];
                    default:          ;
                endcase
            end

            // Compare each result transaction with the oldest one owed
            if (res.valid && res.ready)
            begin
                if (cloud_results.size() == 0)
                begin
                    $error("result with nothing owed: kind %0d", res.kind);
                    fail_count++;
                end
                else
                begin
                    due = cloud_results.pop_front();
                    check_field("kind", due.kind, res.kind);
                    check_field("out_x_mm", due.x, res.out_x_mm);
                    check_field("out_y_mm", due.y, res.out_y_mm);
                    check_field("out_z_mm", due.z, res.out_z_mm);
                    check_field("out_intensity_bits", due.intensity, res.out_intensity_bits);
                    check_field("offset_us", due.offset, res.offset_us);
                    check_field("max_offset_us", due.max_offset, res.max_offset_us);
                    check_field("run_last", due.run_last, res.run_last);
                end
            end

            if (pts.valid && pts.ready)
                filter_point();

            pending <= cloud_results.size();
        end
    end

endmodule

### tb/sv/lidar_point_decimate_range_time_filter_tb.sv
// ----------------------------------------------------------------------------
// lidar_point_decimate_range_time_filter_tb: top of the filter testbench
// Drives directed and random lidar clouds through the block under a range of
// register settings and idle patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module lidar_point_decimate_range_time_filter_tb;
    import lpd_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          RANDOM_ITEMS = 1800;
    localparam int          SETTLE       = 10;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [1:0]  TMODE_REL_NS = 2'd2;
    localparam logic [1:0]  TMODE_NS_ALT = 2'd3;
    localparam logic [63:0] HDR_MID      = 64'h0000_0100_0000_0000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int pending;
    int cycle_cnt = 0;
    int tx_idle   = 0;
    int rx_idle   = 0;
    int hold_req  = 0;
    int hold_done = 0;

    // Stimulus view of the registers
    logic [31:0] cur_max_t = 32'd100000;
    logic [1:0]  cur_mode  = TMODE_REL_S;
    logic [63:0] cur_hdr   = '0;
    int          cur_scale = 10;

    lpd_point_if  points ();
    lpd_result_if results ();

    lidar_point_decimate_range_time_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .points    (points),
        .results   (results)
    );

    lpd_cloud_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pts        (points),
        .res        (results),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Abort the run at the cycle limit
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("lidar_point_decimate_range_time_filter verification failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int left;
        left          = 0;
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0 && hold_done != hold_req)
            begin
                left      = HOLD_CYCLES;
                hold_done = hold_req;
            end
            if (left > 0)
            begin
                results.ready = 1'b0;
                left--;
            end
            else
            begin
                results.ready = ($urandom_range(99) >= rx_idle);
            end
        end
    end

    function automatic logic [63:0] us_to_q32(input logic [63:0] us);
        return ((us / 64'd1000000) << 32) | (((us % 64'd1000000) << 32) / 64'd1000000);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int scale);
        longint span;
        span = longint'(1) << scale;
        case ($urandom_range(19))
            0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
            1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
            2:       return COORD_BITS'($urandom);
            default: return COORD_BITS'(longint'($urandom_range(0, 2 * span - 1)) - span);
        endcase
    endfunction

    // Offer one point and hold it until the transaction completes
    task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input logic signed [COORD_BITS-1:0] z,
                              input logic [31:0] inten, input logic cfin,
                              input logic [63:0] raw, input logic tfin,
                              input logic last);
        while ($urandom_range(99) < tx_idle)
        begin
            @(negedge clk);
            points.valid = 1'b0;
        end
        @(negedge clk);
        points.x_mm           = x;
        points.y_mm           = y;
        points.z_mm           = z;
        points.intensity_bits = inten;
        points.coords_finite  = cfin;
        points.raw_time       = raw;
        points.time_finite    = tfin;
        points.last_point     = last;
        points.valid          = 1'b1;
        do
            @(posedge clk);
        while (!points.ready);
    endtask

    // Stop offering, wait for every owed result, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        points.valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register; narrow registers sometimes get junk above their width
    task automatic cfg_put(input cfg_index_t idx, input logic [63:0] value, input int width);
        logic [63:0] data;
        data = value;
        if (width < 64 && $urandom_range(3) == 0)
            data = value | ({$urandom, $urandom} << width);
        case (idx)
            CFG_MAX_TIME:  cur_max_t = value[31:0];
            CFG_TIME_MODE: cur_mode  = value[1:0];
            CFG_HDR_TIME:  cur_hdr   = value;
            default:       ;
        endcase
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic pick_config();
        logic [63:0] base;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;

        case ($urandom_range(9))
            0:       v = 64'd0;
            1:       v = 64'd255;
            2:       v = $urandom_range(1, 255);
            default: v = $urandom_range(1, 4);
        endcase
        cfg_put(CFG_DECIM, v, 8);

        // Range window, sized to the coordinate spread of this setting
        cur_scale = $urandom_range(4, COORD_BITS - 1);
        base      = 64'd1 << (2 * cur_scale);
        case ($urandom_range(5))
            0:
            begin
                lo = '0;
                hi = 64'hFFFF_FFFF_FFFF;
            end
            1:
            begin
                lo = 64'hFFFF_FFFF_FFFF;
                hi = '0;
            end
            2:
            begin
                lo = '0;
                hi = {$urandom, $urandom};
            end
            default:
            begin
                lo = (base >> 2) * $urandom_range(0, 2);
                hi = (base >> 1) * $urandom_range(1, 5);
            end
        endcase
        cfg_put(CFG_MIN_RSQ, lo, 48);
        cfg_put(CFG_MAX_RSQ, hi, 48);

        case ($urandom_range(9))
            0:       v = 64'd0;
            1:       v = 64'd1;
            2:       v = 64'hFFFF_FFFF;
            3:       v = $urandom;
            4:       v = 64'd100000;
            default: v = $urandom_range(50, 200000);
        endcase
        cfg_put(CFG_MAX_TIME, v, 32);
        cfg_put(CFG_TIME_MODE, $urandom_range(3), 2);

        case ($urandom_range(5))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        cfg_put(CFG_HDR_TIME, v, 64);
        cfg_put(CFG_TIME_PRESENT, $urandom_range(9) != 0, 1);
    endtask

    initial
    begin : stimulus
        logic signed [COORD_BITS-1:0] cmin;
        logic signed [COORD_BITS-1:0] cmax;
        logic [63:0] raw;
        logic [63:0] jit;
        logic        tf;
        longint      tgt;
        int          sent;
        int          len;
        int          r;
        int          ph;
        bit          held;

        cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
        cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
        held = 1'b0;

        points.valid          = 1'b0;
        points.x_mm           = '0;
        points.y_mm           = '0;
        points.z_mm           = '0;
        points.intensity_bits = '0;
        points.coords_finite  = 1'b0;
        points.raw_time       = '0;
        points.time_finite    = 1'b0;
        points.last_point     = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: extremes, fraction at the limit, empty and aborted clouds
        send_point(cmin, cmax, cmin, 32'h0, 1'b1, 64'd0, 1'b1, 1'b0);
        send_point(cmax, cmin, cmax, 32'hFFFF_FFFF, 1'b1, 64'd429496729, 1'b1, 1'b0);
        send_point(5, 5, 5, $urandom, 1'b0, 64'd1000, 1'b1, 1'b1);
        send_point(1, 2, 3, $urandom, 1'b0, 64'd0, 1'b1, 1'b1);
        send_point(7, 8, 9, $urandom, 1'b1, 64'd0, 1'b0, 1'b0);
        send_point(7, 8, 9, $urandom, 1'b1, 64'd0, 1'b1, 1'b0);
        send_point(7, 8, 9, $urandom, 1'b1, 64'd0, 1'b1, 1'b1);
        send_point(1, 1, 1, $urandom, 1'b1, 64'd429496730, 1'b1, 1'b1);

        // Alternate nanosecond code and a decimation factor of zero
        settle();
        cfg_put(CFG_TIME_MODE, TMODE_NS_ALT, 2);
        cfg_put(CFG_DECIM, 64'd0, 8);
        cfg_put(CFG_HDR_TIME, {$urandom, $urandom}, 64);
        send_point(10, -10, 10, $urandom, 1'b1, 64'd0, 1'b1, 1'b0);
        send_point(-10, 10, -10, $urandom, 1'b1, 64'd100000000, 1'b1, 1'b0);
        send_point(3, 3, 3, $urandom, 1'b1, 64'd100000001, 1'b1, 1'b1);
        send_point(3, 3, 3, $urandom, 1'b1, '1, 1'b1, 1'b0);
        send_point(3, 3, 3, $urandom, 1'b1, 64'd0, 1'b1, 1'b1);

        // Absolute seconds around the negative tolerance, a one-value window
        settle();
        cfg_put(CFG_TIME_MODE, TMODE_ABS_S, 2);
        cfg_put(CFG_HDR_TIME, HDR_MID, 64);
        cfg_put(CFG_MIN_RSQ, 64'd25, 48);
        cfg_put(CFG_MAX_RSQ, 64'd25, 48);
        cfg_put(CFG_DECIM, 64'd2, 8);
        send_point(3, 4, 0, $urandom, 1'b1, HDR_MID - 64'd429496, 1'b1, 1'b0);
        send_point(3, 4, 0, $urandom, 1'b1, HDR_MID + 64'd5000000, 1'b1, 1'b0);
        send_point(3, 4, 1, $urandom, 1'b1, HDR_MID, 1'b1, 1'b0);
        // Lower the factor in the middle of the cloud
        settle();
        cfg_put(CFG_DECIM, 64'd1, 8);
        send_point(-3, -4, 0, $urandom, 1'b1, HDR_MID, 1'b1, 1'b0);
        send_point(3, 4, 0, $urandom, 1'b1, HDR_MID - 64'd429497, 1'b1, 1'b1);

        // No time field, then a zero time limit
        settle();
        cfg_put(CFG_TIME_PRESENT, 64'd0, 1);
        cfg_put(CFG_MAX_TIME, 64'd0, 32);
        cfg_put(CFG_TIME_MODE, TMODE_REL_S, 2);
        cfg_put(CFG_MIN_RSQ, 64'd0, 48);
        cfg_put(CFG_MAX_RSQ, 64'hFFFF_FFFF_FFFF, 48);
        send_point(cmax, cmax, cmax, $urandom, 1'b1, '1, 1'b0, 1'b0);
        send_point(cmin, cmin, cmin, $urandom, 1'b1, {$urandom, $urandom}, 1'b1, 1'b1);
        settle();
        cfg_put(CFG_TIME_PRESENT, 64'd1, 1);
        send_point(2, 2, 2, $urandom, 1'b1, 64'd0, 1'b1, 1'b0);
        send_point(2, 2, 2, $urandom, 1'b1, 64'd1, 1'b1, 1'b1);

        // Random clouds under three idle patterns
        for (ph = 0; ph < 3; ph++)
        begin
            settle();
            tx_idle = (ph == 0) ? 9 : (ph == 1) ? 82 : 0;
            rx_idle = (ph == 0) ? 82 : (ph == 1) ? 9 : 0;
            sent    = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                if ($urandom_range(2) == 0)
                begin
                    settle();
                    pick_config();
                end
                // Hold off the receiver while points keep coming
                if (ph == 2 && !held && sent > 200)
                begin
                    hold_req++;
                    held = 1'b1;
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                begin
                    r   = $urandom_range(99);
                    tf  = 1'b1;
                    jit = ($urandom_range(1) == 0) ? 64'd0 : 64'($urandom_range(0, 4294));
                    if (r < 3)
                    begin
                        tf  = 1'b0;
                        raw = {$urandom, $urandom};
                    end
                    else if (r < 7)
                    begin
                        raw = {$urandom, $urandom};
                    end
                    else
                    begin
                        case ($urandom_range(19))
                            0:       tgt = longint'(cur_max_t) + $urandom_range(1, 1000);
                            1:       tgt = longint'(cur_max_t);
                            2:       tgt = -longint'($urandom_range(0, 120));
                            default: tgt = longint'($urandom_range(0, cur_max_t));
                        endcase
                        if (cur_mode == TMODE_ABS_S)
                            raw = (tgt < 0) ? cur_hdr - us_to_q32(-tgt) + jit
                                            : cur_hdr + us_to_q32(tgt) + jit;
                        else if (cur_mode == TMODE_REL_S)
                            raw = us_to_q32((tgt < 0) ? 0 : tgt) + jit;
                        else
                            raw = 64'((tgt < 0) ? 0 : tgt) * 64'd1000 + (jit % 64'd1000);
                    end
                    send_point(rand_coord(cur_scale), rand_coord(cur_scale),
                               rand_coord(cur_scale), $urandom, $urandom_range(9) != 0,
                               raw, tf, k == len - 1);
                    sent++;
                    // Change settings inside a cloud now and then
                    if (k != len - 1 && $urandom_range(99) < 3)
                    begin
                        settle();
                        pick_config();
                    end
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("lidar_point_decimate_range_time_filter verification clean");
        else
            $display("lidar_point_decimate_range_time_filter verification failed");
        $finish;
    end

endmodule
